// File: src/ltc_pkg.sv
package ltc_pkg;

    // Prefix depth kept per word; keywords are matched against it
    localparam int PREFIX_CHARS = 6;
    // Character count saturates at PREFIX_CHARS + 1
    localparam int COUNT_W      = $clog2(PREFIX_CHARS + 2);

    localparam int KW_MAX_LEN   = 6;
    localparam int KW_LEN_W     = 3;
    localparam int KW_COUNT     = 32;

    typedef enum logic [4:0] {
        CAT_EMPTY = 5'd0,
        CAT_MOVE,
        CAT_REPEAT,
        CAT_TO,
        CAT_END,
        CAT_SCREEN,
        CAT_SETPC,
        CAT_OUTPUT,
        CAT_PRINT,
        CAT_IF,
        CAT_STOP,
        CAT_ADD,
        CAT_SUB,
        CAT_MUL,
        CAT_DIV,
        CAT_AND,
        CAT_OR,
        CAT_LBRACKET,
        CAT_RBRACKET,
        CAT_LPAREN,
        CAT_RPAREN,
        CAT_ASSIGN,
        CAT_COMPARE,
        CAT_VARIABLE,
        CAT_PROCEDURE,
        CAT_VALUE,
        CAT_ERROR
    } t_cat;

    typedef enum logic [1:0] {
        FC_OTHER = 2'd0,
        FC_IDENT = 2'd1,
        FC_DIGIT = 2'd2,
        FC_QUOTE = 2'd3
    } t_fclass;

    localparam logic [2:0] DET_NONE   = 3'd0;
    localparam logic [2:0] DET_FD     = 3'd0;
    localparam logic [2:0] DET_BK     = 3'd1;
    localparam logic [2:0] DET_RT     = 3'd2;
    localparam logic [2:0] DET_LT     = 3'd3;
    localparam logic [2:0] DET_PU     = 3'd0;
    localparam logic [2:0] DET_PD     = 3'd1;
    localparam logic [2:0] DET_CS     = 3'd2;
    localparam logic [2:0] DET_EQ     = 3'd0;
    localparam logic [2:0] DET_NE     = 3'd1;
    localparam logic [2:0] DET_GT     = 3'd2;
    localparam logic [2:0] DET_GE     = 3'd3;
    localparam logic [2:0] DET_LT_CMP = 3'd4;
    localparam logic [2:0] DET_LE     = 3'd5;
    localparam logic [2:0] DET_INT    = 3'd0;
    localparam logic [2:0] DET_STRING = 3'd1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_word;
    } t_in_item;

    typedef struct packed {
        t_cat       category;
        logic [2:0] detail;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0]               count;
        logic [PREFIX_CHARS-1:0][7:0]     prefix;
        t_fclass                          first_class;
        logic                             ident_ok;
        logic                             digit_ok;
        logic                             inner_quote;
        logic [7:0]                       prev_ch;
    } t_word_state;

    localparam t_word_state WORD_CLEAR = '{
        count:       '0,
        prefix:      '0,
        first_class: FC_OTHER,
        ident_ok:    1'b1,
        digit_ok:    1'b1,
        inner_quote: 1'b0,
        prev_ch:     '0
    };

    typedef struct packed {
        logic [KW_MAX_LEN-1:0][7:0] text;
        logic [KW_LEN_W-1:0]        len;
        t_cat                       cat;
        logic [2:0]                 det;
    } t_kw;

    // Build a table entry; the string literal is right-aligned, first char highest
    function automatic t_kw kw_make(input logic [8*KW_MAX_LEN-1:0] s, input int len,
                                    input t_cat cat, input logic [2:0] det);
        t_kw e;
        e.text = '0;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < len) begin
                e.text[i] = s[(len - 1 - i) * 8 +: 8];
            end
        end
        e.len = KW_LEN_W'(len);
        e.cat = cat;
        e.det = det;
        return e;
    endfunction

    localparam t_kw KW_TABLE [KW_COUNT] = '{
        kw_make("FD",     2, CAT_MOVE,     DET_FD),
        kw_make("BK",     2, CAT_MOVE,     DET_BK),
        kw_make("RT",     2, CAT_MOVE,     DET_RT),
        kw_make("LT",     2, CAT_MOVE,     DET_LT),
        kw_make("REPEAT", 6, CAT_REPEAT,   DET_NONE),
        kw_make("TO",     2, CAT_TO,       DET_NONE),
        kw_make("END",    3, CAT_END,      DET_NONE),
        kw_make("PU",     2, CAT_SCREEN,   DET_PU),
        kw_make("PD",     2, CAT_SCREEN,   DET_PD),
        kw_make("CS",     2, CAT_SCREEN,   DET_CS),
        kw_make("SETPC",  5, CAT_SETPC,    DET_NONE),
        kw_make("OUTPUT", 6, CAT_OUTPUT,   DET_NONE),
        kw_make("PRINT",  5, CAT_PRINT,    DET_NONE),
        kw_make("IF",     2, CAT_IF,       DET_NONE),
        kw_make("STOP",   4, CAT_STOP,     DET_NONE),
        kw_make("+",      1, CAT_ADD,      DET_NONE),
        kw_make("-",      1, CAT_SUB,      DET_NONE),
        kw_make("*",      1, CAT_MUL,      DET_NONE),
        kw_make("/",      1, CAT_DIV,      DET_NONE),
        kw_make("&&",     2, CAT_AND,      DET_NONE),
        kw_make("||",     2, CAT_OR,       DET_NONE),
        kw_make("[",      1, CAT_LBRACKET, DET_NONE),
        kw_make("]",      1, CAT_RBRACKET, DET_NONE),
        kw_make("(",      1, CAT_LPAREN,   DET_NONE),
        kw_make(")",      1, CAT_RPAREN,   DET_NONE),
        kw_make("=",      1, CAT_ASSIGN,   DET_NONE),
        kw_make("==",     2, CAT_COMPARE,  DET_EQ),
        kw_make("!=",     2, CAT_COMPARE,  DET_NE),
        kw_make(">",      1, CAT_COMPARE,  DET_GT),
        kw_make(">=",     2, CAT_COMPARE,  DET_GE),
        kw_make("<",      1, CAT_COMPARE,  DET_LT_CMP),
        kw_make("<=",     2, CAT_COMPARE,  DET_LE)
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

endpackage

// File: src/ltc_word_track.sv
module ltc_word_track import ltc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    output t_word_state o_next
);

    t_word_state r_word;
    t_word_state n_word;

    // Fold one character into the word state
    always_comb begin
        n_word = r_word;
        for (int i = 0; i < PREFIX_CHARS; i++) begin
            if (r_word.count == COUNT_W'(i)) begin
                n_word.prefix[i] = i_item.ch;
            end
        end
        if (r_word.count == '0) begin
            if (is_ident_start(i_item.ch)) begin
                n_word.first_class = FC_IDENT;
            end else if (is_digit(i_item.ch)) begin
                n_word.first_class = FC_DIGIT;
            end else if (i_item.ch == CH_QUOTE) begin
                n_word.first_class = FC_QUOTE;
            end else begin
                n_word.first_class = FC_OTHER;
            end
        end else begin
            if (!is_ident(i_item.ch)) begin
                n_word.ident_ok = 1'b0;
            end
            if (!is_digit(i_item.ch)) begin
                n_word.digit_ok = 1'b0;
            end
            // a quote that turned out not to be the final character
            if ((r_word.count >= COUNT_W'(2)) && (r_word.prev_ch == CH_QUOTE)) begin
                n_word.inner_quote = 1'b1;
            end
        end
        n_word.prev_ch = i_item.ch;
        if (r_word.count < COUNT_W'(PREFIX_CHARS + 1)) begin
            n_word.count = r_word.count + COUNT_W'(1);
        end
    end

    assign o_next = n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= WORD_CLEAR;
        end else if (i_step) begin
            if (i_item.empty_word || i_item.last) begin
                r_word <= WORD_CLEAR;
            end else begin
                r_word <= n_word;
            end
        end
    end

endmodule

// File: src/ltc_classify.sv
module ltc_classify import ltc_pkg::*; (
    input  t_word_state i_word,
    output t_cat        o_category,
    output logic [2:0]  o_detail
);

    logic       kw_hit;
    t_cat       kw_cat;
    logic [2:0] kw_det;
    logic       entry_ok;

    // Keyword match: length and the leading prefix characters
    always_comb begin
        kw_hit = 1'b0;
        kw_cat = CAT_ERROR;
        kw_det = DET_NONE;
        for (int k = 0; k < KW_COUNT; k++) begin
            entry_ok = (i_word.count == COUNT_W'(KW_TABLE[k].len));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if ((KW_LEN_W'(i) < KW_TABLE[k].len) &&
                    (i_word.prefix[i] != KW_TABLE[k].text[i])) begin
                    entry_ok = 1'b0;
                end
            end
            if (entry_ok && !kw_hit) begin
                kw_hit = 1'b1;
                kw_cat = KW_TABLE[k].cat;
                kw_det = KW_TABLE[k].det;
            end
        end
    end

    always_comb begin
        o_category = CAT_ERROR;
        o_detail   = DET_NONE;
        if (kw_hit) begin
            o_category = kw_cat;
            o_detail   = kw_det;
        end else if (i_word.prefix[0] == CH_COLON) begin
            if ((i_word.count > COUNT_W'(1)) && is_ident_start(i_word.prefix[1]) &&
                i_word.ident_ok) begin
                o_category = CAT_VARIABLE;
            end
        end else begin
            case (i_word.first_class)
                FC_IDENT: begin
                    o_category = i_word.ident_ok ? CAT_PROCEDURE : CAT_ERROR;
                end
                FC_DIGIT: begin
                    o_category = i_word.digit_ok ? CAT_VALUE : CAT_ERROR;
                    o_detail   = DET_INT;
                end
                FC_QUOTE: begin
                    // prev_ch holds the final character here
                    if (!i_word.inner_quote && (i_word.prev_ch == CH_QUOTE)) begin
                        o_category = CAT_VALUE;
                        o_detail   = DET_STRING;
                    end
                end
                default: begin
                    o_category = CAT_ERROR;
                end
            endcase
        end
    end

endmodule

// File: src/logo_word_token_classifier_top.sv
// Path: a word-ending item goes from the input register into the result register and o_item;
//   it leaves the input register only while the result register is free or being drained.
// Throughput: one character item per clock; a word-ending item waits in the input register
//   (raising o_stall) only while the result register is full and i_stall is high.
// Reset: synchronous active-low i_rst_n empties both registers and clears the word
//   state (count, prefix, first-character class, tail flags).
module logo_word_token_classifier_top import ltc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    // Input register: one character item
    logic        r_s1_valid;
    t_in_item    r_s1_item;

    // Result register
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        s1_ends_word;
    logic        out_free;
    logic        s1_go;
    logic        s1_free;
    t_word_state word_next;
    t_cat        cls_category;
    logic [2:0]  cls_detail;
    t_out_item   n_out_item;

    // An item that ends a word needs room in the result register;
    // any other character folds into the word state right away.
    assign s1_ends_word = r_s1_item.empty_word || r_s1_item.last;
    assign out_free     = !r_out_valid || !i_stall;
    assign s1_go        = r_s1_valid && (!s1_ends_word || out_free);
    assign s1_free      = !r_s1_valid || s1_go;
    assign o_stall      = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    // Payload needs no reset; load only on an accepted item
    always_ff @(posedge i_clk) begin
        if (i_valid && s1_free) begin
            r_s1_item <= i_item;
        end
    end

    ltc_word_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_go),
        .i_item  (r_s1_item),
        .o_next  (word_next)
    );

    ltc_classify u_classify (
        .i_word     (word_next),
        .o_category (cls_category),
        .o_detail   (cls_detail)
    );

    // Empty word overrides everything and discards any partial word
    always_comb begin
        if (r_s1_item.empty_word) begin
            n_out_item.category = CAT_EMPTY;
            n_out_item.detail   = DET_NONE;
        end else begin
            n_out_item.category = cls_category;
            n_out_item.detail   = cls_detail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_ends_word) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result while stalled; advance only when a word ends
    always_ff @(posedge i_clk) begin
        if (s1_go && s1_ends_word) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // Upstream stall only ever comes from a held item in the input register
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("o_stall raised with empty input register");

    // A new result follows only a word-ending item that moved on
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && i_stall)) |-> $past(s1_go && s1_ends_word))
        else $error("result without a word-ending item");

    // Empty words and non-coded categories carry a zero detail
    a_empty_detail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.category == CAT_EMPTY || o_item.category == CAT_ERROR ||
                     o_item.category == CAT_PROCEDURE || o_item.category == CAT_VARIABLE))
        |-> (o_item.detail == DET_NONE))
        else $error("nonzero detail on a category without sub-code");

endmodule
